@@ rtl/acrc_pkg.sv @@
// Shared types, constants and helpers for the ref/alt allele caller.
package acrc_pkg;

    // Base counter width and saturation ceiling
    localparam int CNT_W = 18;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // Number of counted bases, in A, G, T, C order
    localparam int NUM_BASES = 4;
    localparam int IDX_W = $clog2(NUM_BASES);

    // ASCII codes of the counted bases
    localparam logic [7:0] ASCII_A = 8'h41;
    localparam logic [7:0] ASCII_G = 8'h47;
    localparam logic [7:0] ASCII_T = 8'h54;
    localparam logic [7:0] ASCII_C = 8'h43;

    // Reference base codes on the result port
    localparam logic [2:0] REF_A = 3'd0;
    localparam logic [2:0] REF_G = 3'd1;
    localparam logic [2:0] REF_T = 3'd2;
    localparam logic [2:0] REF_C = 3'd3;
    localparam logic [2:0] REF_N = 3'd4;

    // Alternate mask bits
    localparam logic [NUM_BASES-1:0] MASK_A = 4'b0001;
    localparam logic [NUM_BASES-1:0] MASK_G = 4'b0010;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic             count_en;   // add this request's alleles
        logic             scan_en;    // compare one counter against the running max
        logic             scan_init;  // first scan step: start from zero and N
        logic [IDX_W-1:0] scan_idx;   // counter under compare
        logic             emit;       // register the call and clear counters
    } cmd_t;

    // One-hot base match of an allele byte, bit order A, G, T, C
    function automatic logic [NUM_BASES-1:0] base_match(input logic [7:0] b);
        logic [NUM_BASES-1:0] m;
        m[0] = (b == ASCII_A);
        m[1] = (b == ASCII_G);
        m[2] = (b == ASCII_T);
        m[3] = (b == ASCII_C);
        return m;
    endfunction

endpackage

@@ rtl/acrc_ctrl.sv @@
// Controller state machine: accepts requests, sequences scan and result.
module acrc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              last_individual,
    output logic              busy,
    output acrc_pkg::cmd_t    cmd
);

    acrc_pkg::state_t                state_reg, state_next;
    logic [acrc_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic                            accept;

    assign busy   = (state_reg != acrc_pkg::ST_IDLE);
    assign accept = start && !busy;

    // Next state and scan index
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            acrc_pkg::ST_IDLE:
            begin
                idx_next = '0;
                if (accept && last_individual)
                begin
                    state_next = acrc_pkg::ST_SCAN;
                end
            end
            acrc_pkg::ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == acrc_pkg::IDX_W'(acrc_pkg::NUM_BASES - 1))
                begin
                    state_next = acrc_pkg::ST_EMIT;
                end
            end
            acrc_pkg::ST_EMIT:
            begin
                state_next = acrc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = acrc_pkg::ST_IDLE;
            end
        endcase
    end

    // Drive datapath commands
    always_comb
    begin
        cmd.count_en  = accept;
        cmd.scan_en   = (state_reg == acrc_pkg::ST_SCAN);
        cmd.scan_init = (state_reg == acrc_pkg::ST_SCAN) && (idx_reg == '0);
        cmd.scan_idx  = idx_reg;
        cmd.emit      = (state_reg == acrc_pkg::ST_EMIT);
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= acrc_pkg::ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

`ifndef SYNTHESIS
    // A request that closes a column must make the block busy
    a_last_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && last_individual) |=> busy)
        else $error("last request did not start the call");

    // Result phase always follows the final scan step
    a_scan_to_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == acrc_pkg::ST_SCAN
         && idx_reg == acrc_pkg::IDX_W'(acrc_pkg::NUM_BASES - 1))
        |=> (state_reg == acrc_pkg::ST_EMIT))
        else $error("scan did not end in result phase");

    // Result phase returns to idle in the next cycle
    a_emit_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == acrc_pkg::ST_EMIT) |=> (state_reg == acrc_pkg::ST_IDLE))
        else $error("result phase did not return to idle");
`endif

endmodule

@@ rtl/acrc_datapath.sv @@
// Datapath: base counters, max scan and call registers.
module acrc_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  acrc_pkg::cmd_t        cmd,
    input  logic                  cfg_write,
    input  logic                  cfg_mode,
    input  logic [7:0]            allele_first,
    input  logic [7:0]            allele_second,
    output logic                  done,
    output logic [2:0]            ref_base,
    output logic [3:0]            alt_mask,
    output logic                  alt_none,
    output logic                  ancestral_is_a
);

    logic [acrc_pkg::NUM_BASES-1:0][acrc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                                   mode_reg;
    logic [acrc_pkg::CNT_W-1:0]             max_reg, max_next;
    logic [2:0]                             best_reg, best_next;
    logic [acrc_pkg::NUM_BASES-1:0]         seen_reg, seen_next;
    logic                                   done_reg;
    logic [2:0]                             ref_reg, ref_next;
    logic [3:0]                             mask_reg, mask_next;
    logic                                   anc_reg;
    logic [acrc_pkg::NUM_BASES-1:0]         m_first, m_second;
    logic [acrc_pkg::CNT_W-1:0]             cur_cnt, run_max;
    logic [2:0]                             run_best;
    logic [acrc_pkg::NUM_BASES-1:0]         run_seen;
    logic [acrc_pkg::NUM_BASES-1:0]         best_bit;

    assign m_first  = acrc_pkg::base_match(allele_first);
    assign m_second = acrc_pkg::base_match(allele_second);

    // Saturating counter update, clear on result
    always_comb
    begin
        logic [1:0]               inc;
        logic [acrc_pkg::CNT_W:0] sum;
        cnt_next = cnt_reg;
        for (int k = 0; k < acrc_pkg::NUM_BASES; k++)
        begin
            inc = {1'b0, m_first[k]} + {1'b0, m_second[k]};
            sum = {1'b0, cnt_reg[k]} + {{(acrc_pkg::CNT_W - 1){1'b0}}, inc};
            if (cmd.emit)
            begin
                cnt_next[k] = '0;
            end
            else if (cmd.count_en)
            begin
                cnt_next[k] = sum[acrc_pkg::CNT_W] ? acrc_pkg::COUNT_MAX
                                                   : sum[acrc_pkg::CNT_W-1:0];
            end
        end
    end

    // One scan step: strict compare keeps ties on the earlier base
    assign cur_cnt  = cnt_reg[cmd.scan_idx];
    assign run_max  = cmd.scan_init ? '0 : max_reg;
    assign run_best = cmd.scan_init ? acrc_pkg::REF_N : best_reg;
    assign run_seen = cmd.scan_init ? '0 : seen_reg;

    always_comb
    begin
        max_next  = max_reg;
        best_next = best_reg;
        seen_next = seen_reg;
        if (cmd.scan_en)
        begin
            max_next  = run_max;
            best_next = run_best;
            seen_next = run_seen;
            if (cur_cnt > run_max)
            begin
                max_next  = cur_cnt;
                best_next = {1'b0, cmd.scan_idx};
            end
            seen_next[cmd.scan_idx] = (cur_cnt != '0);
        end
    end

    // Form the call
    always_comb
    begin
        best_bit = '0;
        if (best_reg != acrc_pkg::REF_N)
        begin
            best_bit[best_reg[acrc_pkg::IDX_W-1:0]] = 1'b1;
        end
        if (mode_reg)
        begin
            if (cnt_reg[0] > cnt_reg[1])
            begin
                ref_next  = acrc_pkg::REF_A;
                mask_next = acrc_pkg::MASK_G;
            end
            else
            begin
                ref_next  = acrc_pkg::REF_G;
                mask_next = acrc_pkg::MASK_A;
            end
        end
        else
        begin
            ref_next  = best_reg;
            mask_next = seen_reg & ~best_bit;
        end
    end

    // Hold counters, mode and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            mode_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= cmd.emit;
            if (cfg_write)
            begin
                mode_reg <= cfg_mode;
            end
        end
    end

    // Scan and result payload
    always_ff @(posedge clk)
    begin
        max_reg  <= max_next;
        best_reg <= best_next;
        seen_reg <= seen_next;
        if (cmd.emit)
        begin
            ref_reg  <= ref_next;
            mask_reg <= mask_next;
            anc_reg  <= mode_reg;
        end
    end

    assign done           = done_reg;
    assign ref_base       = ref_reg;
    assign alt_mask       = mask_reg;
    assign alt_none       = (mask_reg == '0);
    assign ancestral_is_a = anc_reg;

`ifndef SYNTHESIS
    // Counters are empty right after a result
    a_clear_after_call: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (cnt_reg == '0))
        else $error("counters not cleared after result");

    // Biallelic call never names T, C or N
    a_bi_ref: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && anc_reg) |-> (ref_reg == acrc_pkg::REF_A
                                   || ref_reg == acrc_pkg::REF_G))
        else $error("biallelic reference outside A/G");

    // The reference base is never listed as an alternate
    a_ref_not_alt: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && ref_reg != acrc_pkg::REF_N)
        |-> !mask_reg[ref_reg[acrc_pkg::IDX_W-1:0]])
        else $error("reference also marked alternate");
`endif

endmodule

@@ rtl/allele_count_ref_alt_caller.sv @@
// Top level of the reference/alternate allele caller for one SNP column.
//
// Requests: one individual per request, taken when start is high and busy is
// low; allele_first/allele_second are ASCII bytes, A G T C are counted.
// last_individual closes the column. Non-final requests are taken back to
// back, one per cycle. After a final request busy rises while the block
// steps one shared 18-bit comparator over the A, G, T, C counters in turn
// to find the most frequent base, then forms the call and clears the
// counters. done pulses for one cycle with ref_base, alt_mask, alt_none and
// ancestral_is_a in the first cycle that busy is low again; the receiver
// cannot stall it, and the next column may start in the cycle done is high.
// Configuration: biallelic_mode is written through cfg_valid/cfg_ready; the
// user must write it only while no column is in flight, which the block does
// not enforce itself; cfg_ready is always high.
// Reset (rst_n low, asynchronous): counters cleared, full four-base mode,
// controller idle, no result pending.
module allele_count_ref_alt_caller (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [7:0] allele_first,
    input  logic [7:0] allele_second,
    input  logic       last_individual,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       biallelic_mode,
    output logic       done,
    output logic [2:0] ref_base,
    output logic [3:0] alt_mask,
    output logic       alt_none,
    output logic       ancestral_is_a
);

    acrc_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    // Sequence requests
    acrc_ctrl u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .last_individual (last_individual),
        .busy            (busy),
        .cmd             (cmd)
    );

    // Count and call
    acrc_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_write      (cfg_valid && cfg_ready),
        .cfg_mode       (biallelic_mode),
        .allele_first   (allele_first),
        .allele_second  (allele_second),
        .done           (done),
        .ref_base       (ref_base),
        .alt_mask       (alt_mask),
        .alt_none       (alt_none),
        .ancestral_is_a (ancestral_is_a)
    );

endmodule

@@ dv/allele_count_ref_alt_caller_tb.sv @@
// Self-checking testbench for the reference/alternate allele caller.
`timescale 1ns / 100ps

module allele_count_ref_alt_caller_tb;

    localparam int CLK_HALF_NS = 6;
    localparam longint STOP_NS = 64'd24_000_000;
    localparam int DRAIN_LIMIT = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam logic [7:0] ASCII_N = 8'h4E;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic MODE_FULL = 1'b0;
    localparam logic MODE_BIALLELIC = 1'b1;

    typedef struct packed {
        logic [2:0] ref_base;
        logic [3:0] alt_mask;
        logic       alt_none;
        logic       ancestral_is_a;
    } allele_call_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [7:0] allele_first = '0;
    logic [7:0] allele_second = '0;
    logic       last_individual = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       biallelic_mode = 1'b0;
    logic       done;
    logic [2:0] ref_base;
    logic [3:0] alt_mask;
    logic       alt_none;
    logic       ancestral_is_a;

    // Predictor state: per-base tallies in A, G, T, C order and calling mode
    logic [acrc_pkg::CNT_W-1:0] base_tally [acrc_pkg::NUM_BASES];
    logic             call_mode = MODE_FULL;
    allele_call_t     call_q [$];
    int               fail_count = 0;

    // Sender burst control
    bit gaps_on = 1'b1;
    int burst_left = 4;

    allele_count_ref_alt_caller dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .allele_first   (allele_first),
        .allele_second  (allele_second),
        .last_individual(last_individual),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .biallelic_mode (biallelic_mode),
        .done           (done),
        .ref_base       (ref_base),
        .alt_mask       (alt_mask),
        .alt_none       (alt_none),
        .ancestral_is_a (ancestral_is_a)
    );

    always #(CLK_HALF_NS) clk = ~clk;

    // Map an allele byte to its tally slot, -1 for uncounted bytes
    function automatic int allele_slot(input logic [7:0] b);
        case (b)
            acrc_pkg::ASCII_A: return 0;
            acrc_pkg::ASCII_G: return 1;
            acrc_pkg::ASCII_T: return 2;
            acrc_pkg::ASCII_C: return 3;
            default: return -1;
        endcase
    endfunction

    // Bump one tally, holding it at the ceiling
    task automatic tally_allele(input logic [7:0] b);
        int k;
        k = allele_slot(b);
        if (k >= 0 && base_tally[k] != acrc_pkg::COUNT_MAX)
            base_tally[k] = base_tally[k] + 1'b1;
    endtask

    // Form the call for the closed column and clear the tallies
    task automatic close_column();
        allele_call_t c;
        logic [acrc_pkg::CNT_W-1:0] top;
        c = '0;
        if (call_mode == MODE_BIALLELIC)
        begin
            c.ref_base = (base_tally[0] > base_tally[1]) ? acrc_pkg::REF_A
                                                         : acrc_pkg::REF_G;
            c.alt_mask = (c.ref_base == acrc_pkg::REF_A) ? acrc_pkg::MASK_G
                                                         : acrc_pkg::MASK_A;
            c.ancestral_is_a = 1'b1;
        end
        else
        begin
            c.ref_base = acrc_pkg::REF_N;
            top = '0;
            for (int k = 0; k < acrc_pkg::NUM_BASES; k++)
            begin
                if (base_tally[k] > top)
                begin
                    top = base_tally[k];
                    c.ref_base = 3'(k);
                end
            end
            for (int k = 0; k < acrc_pkg::NUM_BASES; k++)
            begin
                if (3'(k) != c.ref_base && base_tally[k] != '0)
                    c.alt_mask[k] = 1'b1;
            end
        end
        c.alt_none = (c.alt_mask == '0);
        call_q.push_back(c);
        for (int k = 0; k < acrc_pkg::NUM_BASES; k++)
            base_tally[k] = '0;
    endtask

    // Send one individual; start stays high for a following request
    task automatic send_individual(input logic [7:0] a, input logic [7:0] b,
                                   input logic fin);
        int gap;
        @(negedge clk);
        start = 1'b1;
        allele_first = a;
        allele_second = b;
        last_individual = fin;
        do
            @(posedge clk);
        while (busy);
        tally_allele(a);
        tally_allele(b);
        if (fin)
            close_column();
        // Insert a random gap at the end of a burst
        if (gaps_on)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                gap = $urandom_range(1, 6);
                @(negedge clk);
                start = 1'b0;
                allele_first = 8'($urandom);
                allele_second = 8'($urandom);
                last_individual = 1'($urandom);
                repeat (gap - 1) @(negedge clk);
                burst_left = $urandom_range(1, 12);
            end
        end
    endtask

    // Drop start and wait for every pending call, then let the block settle
    task automatic drain_calls();
        int waited;
        @(negedge clk);
        start = 1'b0;
        waited = 0;
        while (call_q.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (call_q.size() != 0)
        begin
            $error("missing %0d call(s) from the block", call_q.size());
            fail_count++;
            call_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the mode register through its handshake
    task automatic write_mode(input logic m);
        @(negedge clk);
        start = 1'b0;
        cfg_valid = 1'b1;
        biallelic_mode = m;
        do
            @(posedge clk);
        while (!cfg_ready);
        call_mode = m;
        @(negedge clk);
        cfg_valid = 1'b0;
        biallelic_mode = 1'($urandom);
    endtask

    // Pick an allele byte, mostly the column's favored base
    function automatic logic [7:0] pick_allele(input logic [7:0] favored);
        logic [7:0] bases [acrc_pkg::NUM_BASES];
        int r;
        bases = '{acrc_pkg::ASCII_A, acrc_pkg::ASCII_G, acrc_pkg::ASCII_T,
                  acrc_pkg::ASCII_C};
        r = $urandom_range(0, 9);
        if (r < 4)
            return favored;
        if (r < 8)
            return bases[$urandom_range(0, acrc_pkg::NUM_BASES - 1)];
        if (r == 8)
            return 8'($urandom_range(0, 255));
        return ASCII_N;
    endfunction

    // Reset mode default: an empty column calls N
    task automatic test_reset_default();
        send_individual(ASCII_N, ASCII_N, 1'b1);
        drain_calls();
    endtask

    // Full mode: single base, ties, majority, ignored bytes
    task automatic test_full_mode();
        write_mode(MODE_FULL);
        send_individual(acrc_pkg::ASCII_A, acrc_pkg::ASCII_A, 1'b1);
        send_individual(acrc_pkg::ASCII_A, acrc_pkg::ASCII_G, 1'b0);
        send_individual(8'h00, 8'hFF, 1'b1);
        send_individual(acrc_pkg::ASCII_T, acrc_pkg::ASCII_C, 1'b1);
        send_individual(acrc_pkg::ASCII_C, acrc_pkg::ASCII_C, 1'b0);
        send_individual(acrc_pkg::ASCII_G, acrc_pkg::ASCII_T, 1'b0);
        send_individual(acrc_pkg::ASCII_A, acrc_pkg::ASCII_C, 1'b1);
        send_individual(ASCII_LOWER_A, 8'h80, 1'b1);
        send_individual(acrc_pkg::ASCII_G, acrc_pkg::ASCII_G, 1'b0);
        send_individual(acrc_pkg::ASCII_T, acrc_pkg::ASCII_T, 1'b1);
        drain_calls();
    endtask

    // Biallelic mode: empty column, A over G, tie, only T/C
    task automatic test_biallelic_mode();
        write_mode(MODE_BIALLELIC);
        send_individual(ASCII_N, ASCII_N, 1'b1);
        send_individual(acrc_pkg::ASCII_A, acrc_pkg::ASCII_A, 1'b0);
        send_individual(acrc_pkg::ASCII_G, acrc_pkg::ASCII_T, 1'b1);
        send_individual(acrc_pkg::ASCII_A, acrc_pkg::ASCII_G, 1'b1);
        send_individual(acrc_pkg::ASCII_T, acrc_pkg::ASCII_C, 1'b1);
        send_individual(8'hFF, 8'h00, 1'b0);
        send_individual(acrc_pkg::ASCII_A, acrc_pkg::ASCII_C, 1'b1);
        drain_calls();
    endtask

    // Mode change inside a column: the mode at the closing request decides
    task automatic test_mode_switch();
        write_mode(MODE_BIALLELIC);
        send_individual(acrc_pkg::ASCII_G, acrc_pkg::ASCII_G, 1'b0);
        send_individual(acrc_pkg::ASCII_T, acrc_pkg::ASCII_T, 1'b0);
        drain_calls();
        write_mode(MODE_FULL);
        send_individual(acrc_pkg::ASCII_T, acrc_pkg::ASCII_C, 1'b1);
        send_individual(acrc_pkg::ASCII_A, acrc_pkg::ASCII_A, 1'b0);
        drain_calls();
        write_mode(MODE_BIALLELIC);
        send_individual(acrc_pkg::ASCII_G, acrc_pkg::ASCII_T, 1'b1);
        drain_calls();
    endtask

    // Random columns over several mode phases
    task automatic test_random_columns();
        logic [7:0] bases [acrc_pkg::NUM_BASES];
        logic [7:0] favored;
        int sent;
        int len;
        bases = '{acrc_pkg::ASCII_A, acrc_pkg::ASCII_G, acrc_pkg::ASCII_T,
                  acrc_pkg::ASCII_C};
        for (int p = 0; p < 8; p++)
        begin
            if (p < 2)
                write_mode(p[0]);
            else
                write_mode(1'($urandom));
            gaps_on = (p % 3 != 2);
            sent = 0;
            while (sent < 62)
            begin
                len = ($urandom_range(0, 15) == 0) ? $urandom_range(11, 40)
                                                    : $urandom_range(1, 10);
                favored = bases[$urandom_range(0, acrc_pkg::NUM_BASES - 1)];
                for (int i = 0; i < len; i++)
                    send_individual(pick_allele(favored), pick_allele(favored),
                                    i == len - 1);
                sent += len;
            end
            drain_calls();
        end
    endtask

    // Compare each call with the oldest prediction
    always @(posedge clk)
    begin : check_call
        allele_call_t want;
        if (rst_n && done)
        begin
            if (call_q.size() == 0)
            begin
                $error("call with no request pending: ref_base %0d alt_mask %0h",
                       ref_base, alt_mask);
                fail_count++;
            end
            else
            begin
                want = call_q.pop_front();
                if (ref_base !== want.ref_base)
                begin
                    $error("ref_base: expected %0d, actual %0d", want.ref_base, ref_base);
                    fail_count++;
                end
                if (alt_mask !== want.alt_mask)
                begin
                    $error("alt_mask: expected %0h, actual %0h", want.alt_mask, alt_mask);
                    fail_count++;
                end
                if (alt_none !== want.alt_none)
                begin
                    $error("alt_none: expected %0d, actual %0d", want.alt_none, alt_none);
                    fail_count++;
                end
                if (ancestral_is_a !== want.ancestral_is_a)
                begin
                    $error("ancestral_is_a: expected %0d, actual %0d",
                           want.ancestral_is_a, ancestral_is_a);
                    fail_count++;
                end
            end
        end
    end

    // Stop a hung run
    initial
    begin
        #(STOP_NS);
        $display("tb: failure");
        $finish;
    end

    // Main sequence
    initial
    begin
        for (int k = 0; k < acrc_pkg::NUM_BASES; k++)
            base_tally[k] = '0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        test_reset_default();
        test_full_mode();
        test_biallelic_mode();
        test_mode_switch();
        test_random_columns();
        drain_calls();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ allele_count_ref_alt_caller.f @@
rtl/acrc_pkg.sv
rtl/acrc_ctrl.sv
rtl/acrc_datapath.sv
rtl/allele_count_ref_alt_caller.sv
dv/allele_count_ref_alt_caller_tb.sv
